// File: sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// Triangle face normal package
// Shared kind codes and fixed widths for the face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

   // Transaction kinds.
   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_FACE   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   localparam int IndexBits  = 10;
   localparam int FieldBits  = 16;
   localparam int NormalBits = 16;

endpackage

// File: sv/triangle_face_normal_scatter_core.sv
// ----------------------------------------------------------------------------
// Triangle face normal core
// Vertex store, normal store and an iterative unit normal engine.
// ----------------------------------------------------------------------------
// A vertex write, or an update begin that does not exhaust the epoch values,
// leaves the core idle and ready for the next transaction. Each normal memory
// entry carries an 8 bit epoch tag, and an update begin only advances the
// current epoch. When the epoch values run out, the update begin starts a
// clearing pass over all VERTEX_COUNT normal memory entries; the same pass runs
// after reset, and the input is stalled until it ends. A normal read passes
// through S_RDN, S_RDW and S_OUT before the core returns to idle. A face goes
// through three vertex reads from the single port vertex memory, the cross
// product on one shared multiplier, a normalization step, the sum of squares,
// a 32 step square root, three divisions, three normal memory writes, the
// output state and the return to idle. A face with a zero cross product skips
// the sum of squares, the square root and the divisions. Items are handled one
// at a time, and no transaction is accepted while a finished result is stalled
// in the output register.
module triangle_face_normal_scatter_core #(
   parameter int VERTEX_COUNT = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic [tfn_pkg::IndexBits-1:0] req_first_index,
   input  logic [tfn_pkg::IndexBits-1:0] req_second_index,
   input  logic [tfn_pkg::IndexBits-1:0] req_third_index,
   input  logic signed [tfn_pkg::FieldBits-1:0] req_coord_x,
   input  logic signed [tfn_pkg::FieldBits-1:0] req_coord_y,
   input  logic signed [tfn_pkg::FieldBits-1:0] req_coord_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [tfn_pkg::NormalBits-1:0] rsp_normal_x,
   output logic signed [tfn_pkg::NormalBits-1:0] rsp_normal_y,
   output logic signed [tfn_pkg::NormalBits-1:0] rsp_normal_z,
   output logic                         rsp_degenerate,
   output logic                         rsp_from_read
);
   import tfn_pkg::*;

   localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int CB  = COORD_BITS;
   localparam int DB  = CB + 1;                 // raw difference width
   localparam int RSH = (CB > 16) ? CB - 16 : 0;
   localparam int EB  = DB - RSH;               // reduced difference width
   localparam int PB  = 2 * EB + 1;             // cross component width
   localparam int NB  = NormalBits;
   localparam int EpochBits = 8;
   localparam int NW  = 3 * NB + EpochBits;     // normal entry with epoch tag
   localparam logic [EpochBits-1:0] EpochFirst = EpochBits'(1);
   localparam logic [EpochBits-1:0] EpochLast  = '1;

   typedef enum logic [14:0] {
      S_IDLE = 15'b000000000000001,
      S_RD0  = 15'b000000000000010,
      S_RD1  = 15'b000000000000100,
      S_RD2  = 15'b000000000001000,
      S_CAP  = 15'b000000000010000,
      S_MUL  = 15'b000000000100000,
      S_NORM = 15'b000000001000000,
      S_SQ   = 15'b000000010000000,
      S_SQRT = 15'b000000100000000,
      S_DIV  = 15'b000001000000000,
      S_WR   = 15'b000010000000000,
      S_OUT  = 15'b000100000000000,
      S_RDN  = 15'b001000000000000,
      S_RDW  = 15'b010000000000000,
      S_CLR  = 15'b100000000000000
   } state_type;

   // Memories.
   logic [3*CB-1:0] vmem [VERTEX_COUNT];
   logic [NW-1:0] nmem [VERTEX_COUNT];

   state_type state_ff, state_in;
   logic [IndexBits-1:0] idx_ff [3];
   logic [1:0] cnt_ff;
   logic [5:0] step_ff;
   logic [3*CB-1:0] vrd_ff;
   logic [NW-1:0] nrd_ff;
   logic [EpochBits-1:0] epoch_ff;
   logic [AW-1:0] clr_addr_ff;
   logic signed [CB-1:0] va_ff [3];
   logic signed [CB-1:0] vb_ff [3];
   logic signed [EB-1:0] e_ff [3];
   logic signed [EB-1:0] f_ff [3];
   logic signed [PB-1:0] x_ff [3];
   logic signed [2*EB-1:0] prod_ff;
   logic [31:0] mag_ff [3];
   logic [63:0] sum_ff, rem_ff, res_ff;
   logic [31:0] len_ff;
   logic [47:0] dnum_ff;
   logic [31:0] drem_ff;
   logic [NB-1:0] n_ff [3];
   logic degen_ff, rdvalid_ff;
   logic rsp_valid_ff;
   logic [NB-1:0] out_n_ff [3];
   logic out_degen_ff, out_read_ff;

   logic accept;
   assign req_stall = !(state_ff == S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   function automatic logic [AW-1:0] idx_addr(input logic [IndexBits-1:0] i);
      logic [31:0] w;
      w = 32'(i);
      return w[AW-1:0];
   endfunction

   function automatic logic idx_ok(input logic [IndexBits-1:0] i);
      return 32'(i) < 32'(VERTEX_COUNT);
   endfunction

   // Reduce a difference by 2^RSH, truncating toward zero.
   function automatic logic signed [EB-1:0] reduce_diff(input logic signed [DB-1:0] d);
      logic signed [DB-1:0] biased;
      biased = d + (d[DB-1] ? DB'((1 << RSH) - 1) : DB'(0));
      return EB'(biased >>> RSH);
   endfunction

   // Vertex memory: one synchronous port.
   logic vwe;
   logic [AW-1:0] vaddr;
   always_comb begin
      vwe = accept && (kind_type'(req_kind) == KIND_VERTEX) && idx_ok(req_first_index);
      vaddr = vwe ? idx_addr(req_first_index) : idx_addr(idx_ff[cnt_ff]);
   end
   always_ff @(posedge clock) begin
      if (vwe) begin
         vmem[vaddr] <= {CB'($unsigned(req_coord_z)), CB'($unsigned(req_coord_y)),
                         CB'($unsigned(req_coord_x))};
      end
      vrd_ff <= vmem[vaddr];
   end

   // Normal memory: one synchronous port, cleared to tag zero by the pass.
   logic nwe;
   logic [AW-1:0] naddr;
   logic [NW-1:0] nwdata;
   always_comb begin
      nwe = ((state_ff == S_WR) && idx_ok(idx_ff[cnt_ff])) || (state_ff == S_CLR);
      naddr = (state_ff == S_CLR) ? clr_addr_ff : idx_addr(idx_ff[cnt_ff]);
      nwdata = (state_ff == S_CLR) ? '0 : {epoch_ff, n_ff[2], n_ff[1], n_ff[0]};
   end
   always_ff @(posedge clock) begin
      if (nwe) begin
         nmem[naddr] <= nwdata;
      end
      nrd_ff <= nmem[naddr];
   end

   // Vertex fetched this cycle, treated as zero when out of range.
   logic [1:0] prev_cnt;
   assign prev_cnt = cnt_ff - 2'd1;
   logic vok_ff;

   // Cross product operand selection for the shared multiplier.
   logic signed [EB-1:0] ma, mb;
   always_comb begin
      case (step_ff[2:0])
         3'd0: begin ma = e_ff[1]; mb = f_ff[2]; end
         3'd1: begin ma = e_ff[2]; mb = f_ff[1]; end
         3'd2: begin ma = e_ff[2]; mb = f_ff[0]; end
         3'd3: begin ma = e_ff[0]; mb = f_ff[2]; end
         3'd4: begin ma = e_ff[0]; mb = f_ff[1]; end
         default: begin ma = e_ff[1]; mb = f_ff[0]; end
      endcase
   end

   // Normalization shift.
   logic [PB-1:0] amag [3];
   logic [PB-1:0] top;
   logic [6:0] p;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         amag[i] = x_ff[i][PB-1] ? PB'(-x_ff[i]) : PB'(x_ff[i]);
      end
      top = amag[0] | amag[1] | amag[2];
      p = '0;
      for (int b = 0; b < PB; b++) begin
         if (top[b]) p = 7'(b);
      end
   end

   // Square root step.
   logic [63:0] sq_bit, sq_trial;
   assign sq_bit = 64'd1 << (7'd62 - {step_ff, 1'b0});
   assign sq_trial = res_ff + sq_bit;

   // Divide step: restoring, one quotient bit per cycle.
   logic [32:0] dshift, dsub;
   assign dshift = {drem_ff, dnum_ff[47]};
   assign dsub = dshift - {1'b0, len_ff};

   logic [1:0] ci;
   assign ci = cnt_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            case (kind_type'(req_kind))
               KIND_FACE: state_in = S_RD0;
               KIND_READ: state_in = S_RDN;
               KIND_CLEAR: state_in = (epoch_ff == EpochLast) ? S_CLR : S_IDLE;
               default: state_in = S_IDLE;
            endcase
         end
         S_RD0: state_in = S_RD1;
         S_RD1: state_in = S_RD2;
         S_RD2: state_in = S_CAP;
         S_CAP: state_in = S_MUL;
         S_MUL: if (step_ff == 6'd6) state_in = S_NORM;
         S_NORM: state_in = (top == '0) ? S_WR : S_SQ;
         S_SQ: if (cnt_ff == 2'd3) state_in = S_SQRT;
         S_SQRT: if (step_ff == 6'd31) state_in = S_DIV;
         S_DIV: if (step_ff == 6'd48 && cnt_ff == 2'd2) state_in = S_WR;
         S_WR: if (cnt_ff == 2'd2) state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         S_RDN: state_in = S_RDW;
         S_RDW: state_in = S_OUT;
         S_CLR: if (clr_addr_ff == AW'(VERTEX_COUNT - 1)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_addr_ff <= '0;
         epoch_ff <= EpochFirst;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               step_ff <= '0;
               if (accept) begin
                  idx_ff[0] <= req_first_index;
                  idx_ff[1] <= req_second_index;
                  idx_ff[2] <= req_third_index;
                  // An update begin retires the current epoch.
                  if (kind_type'(req_kind) == KIND_CLEAR) begin
                     if (epoch_ff == EpochLast) begin
                        epoch_ff <= EpochFirst;
                        clr_addr_ff <= '0;
                     end else begin
                        epoch_ff <= epoch_ff + EpochBits'(1);
                     end
                  end
               end
            end
            S_CLR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
            end
            S_RD0, S_RD1, S_RD2: begin
               // Memory data arrives in the cycle after the address.
               cnt_ff <= cnt_ff + 2'd1;
               vok_ff <= idx_ok(idx_ff[cnt_ff]);
               if (state_ff != S_RD0) begin
                  for (int i = 0; i < 3; i++) begin
                     if (prev_cnt == 2'd0)
                        va_ff[i] <= vok_ff ? vrd_ff[i*CB +: CB] : '0;
                     else
                        vb_ff[i] <= vok_ff ? vrd_ff[i*CB +: CB] : '0;
                  end
               end
            end
            S_CAP: begin
               // Third vertex arrives; form reduced edge vectors.
               for (int i = 0; i < 3; i++) begin
                  logic signed [DB-1:0] cv, dv, ev;
                  cv = vok_ff ? DB'(signed'(vrd_ff[i*CB +: CB])) : '0;
                  dv = DB'(vb_ff[i]) - DB'(va_ff[i]);
                  ev = cv - DB'(va_ff[i]);
                  e_ff[i] <= reduce_diff(dv);
                  f_ff[i] <= reduce_diff(ev);
               end
               step_ff <= '0;
            end
            S_MUL: begin
               // Shared multiplier: product registered, then accumulated.
               step_ff <= step_ff + 6'd1;
               prod_ff <= ma * mb;
               if (step_ff != 6'd0) begin
                  case (step_ff[2:0])
                     3'd1: x_ff[0] <= PB'(prod_ff);
                     3'd2: x_ff[0] <= x_ff[0] - PB'(prod_ff);
                     3'd3: x_ff[1] <= PB'(prod_ff);
                     3'd4: x_ff[1] <= x_ff[1] - PB'(prod_ff);
                     3'd5: x_ff[2] <= PB'(prod_ff);
                     default: x_ff[2] <= x_ff[2] - PB'(prod_ff);
                  endcase
               end
            end
            S_NORM: begin
               cnt_ff <= '0;
               sum_ff <= '0;
               degen_ff <= (top == '0);
               if (top == '0) begin
                  for (int i = 0; i < 3; i++) n_ff[i] <= '0;
               end
               for (int i = 0; i < 3; i++) begin
                  logic [PB+31:0] w;
                  w = (PB+32)'(amag[i]);
                  if (p < 7'd30) w = w << (7'd30 - p);
                  else w = w >> (p - 7'd30);
                  mag_ff[i] <= w[31:0];
               end
            end
            S_SQ: begin
               // Sum of squares, one term per cycle.
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff != 2'd3) begin
                  sum_ff <= sum_ff + 64'(mag_ff[cnt_ff]) * 64'(mag_ff[cnt_ff]);
               end else begin
                  rem_ff <= sum_ff;
                  res_ff <= '0;
                  step_ff <= '0;
               end
            end
            S_SQRT: begin
               if (rem_ff >= sq_trial) begin
                  rem_ff <= rem_ff - sq_trial;
                  res_ff <= (res_ff >> 1) + sq_bit;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               if (step_ff == 6'd31) begin
                  len_ff <= (rem_ff >= sq_trial) ? 32'((res_ff >> 1) + sq_bit)
                                                 : 32'(res_ff >> 1);
                  cnt_ff <= '0;
                  step_ff <= '0;
               end else begin
                  step_ff <= step_ff + 6'd1;
               end
            end
            S_DIV: begin
               // Step 0 loads the numerator, steps 1..48 develop the quotient.
               if (step_ff == 6'd0) begin
                  dnum_ff <= (48'(mag_ff[ci]) << 14) + 48'(len_ff >> 1);
                  drem_ff <= '0;
                  step_ff <= 6'd1;
               end else begin
                  if (!dsub[32]) begin
                     drem_ff <= dsub[31:0];
                     dnum_ff <= {dnum_ff[46:0], 1'b1};
                  end else begin
                     drem_ff <= dshift[31:0];
                     dnum_ff <= {dnum_ff[46:0], 1'b0};
                  end
                  if (step_ff == 6'd48) begin
                     logic [NB-1:0] q;
                     q = NB'({dnum_ff[46:0], !dsub[32]});
                     n_ff[ci] <= x_ff[ci][PB-1] ? NB'(-q) : q;
                     step_ff <= '0;
                     cnt_ff <= (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
                  end else begin
                     step_ff <= step_ff + 6'd1;
                  end
               end
               rdvalid_ff <= 1'b0;
            end
            S_WR: begin
               cnt_ff <= (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
               rdvalid_ff <= 1'b0;
            end
            S_RDN: begin
               rdvalid_ff <= idx_ok(idx_ff[0]);
               degen_ff <= 1'b0;
            end
            S_RDW: begin
               // An entry counts only when its tag matches the current epoch.
               for (int i = 0; i < 3; i++)
                  n_ff[i] <= (rdvalid_ff && (nrd_ff[3*NB +: EpochBits] == epoch_ff))
                             ? nrd_ff[i*NB +: NB] : '0;
               rdvalid_ff <= 1'b1;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               for (int i = 0; i < 3; i++) out_n_ff[i] <= n_ff[i];
               out_degen_ff <= degen_ff;
               out_read_ff <= rdvalid_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_normal_x = out_n_ff[0];
   assign rsp_normal_y = out_n_ff[1];
   assign rsp_normal_z = out_n_ff[2];
   assign rsp_degenerate = out_degen_ff;
   assign rsp_from_read = out_read_ff;

   // A result becomes valid only after passing through the S_OUT state.
   a_out_from_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT)) else $error("result without finish");
   // A read result is never flagged degenerate.
   a_read_not_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_read |-> !rsp_degenerate) else $error("degenerate read");
   // Normal memory is written only by face writeback or the clearing pass.
   a_nwe_state: assert property (@(posedge clock) disable iff (reset)
      nwe |-> (state_ff == S_WR) || (state_ff == S_CLR)) else $error("stray normal write");

endmodule

// File: tb/triangle_face_normal_scatter_core_test.sv
// ----------------------------------------------------------------------------
// Triangle face normal core testbench
// Drives vertex writes, update begins, faces and normal reads, predicts each
// result with a local fixed-point normal calculation, and checks every result.
// ----------------------------------------------------------------------------
module triangle_face_normal_scatter_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tfn_pkg::*;

   localparam int VertexCount = 1024;
   localparam int IdleLimit   = 20000;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               degenerate;
      logic               from_read;
   } normal_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = KIND_VERTEX;
   logic [9:0] req_first_index = '0;
   logic [9:0] req_second_index = '0;
   logic [9:0] req_third_index = '0;
   logic signed [15:0] req_coord_x = '0;
   logic signed [15:0] req_coord_y = '0;
   logic signed [15:0] req_coord_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate, rsp_from_read;

   // Local copy of the block's stores.
   logic signed [15:0] vertex_mem [VertexCount][3];
   bit                 vertex_written [VertexCount];
   normal_result_type  normal_mem [VertexCount];
   bit                 normal_ok [VertexCount];

   normal_result_type pending_normals[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  stalls_on = 1'b1;

   triangle_face_normal_scatter_core u_dut (.*);

   always #1 clock = ~clock;

   // Square root, floor.
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Unit normal of the face a, b, c in Q1.14.
   function automatic normal_result_type face_unit_normal(int ia, int ib, int ic);
      normal_result_type r;
      longint e[3], f[3], x[3];
      longint unsigned mag[3], top, sum, len, q;
      int p;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         e[i] = longint'(vertex_mem[ib][i]) - longint'(vertex_mem[ia][i]);
         f[i] = longint'(vertex_mem[ic][i]) - longint'(vertex_mem[ia][i]);
      end
      x[0] = e[1] * f[2] - e[2] * f[1];
      x[1] = e[2] * f[0] - e[0] * f[2];
      x[2] = e[0] * f[1] - e[1] * f[0];
      top = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = x[i] < 0 ? -x[i] : x[i];
         if (mag[i] > top) top = mag[i];
      end
      if (top == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      p = 0;
      while ((top >> p) > 1) p++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         if (p < 30) mag[i] <<= (30 - p);
         else mag[i] >>= (p - 30);
         sum += mag[i] * mag[i];
      end
      len = root_floor(sum);
      q = (mag[0] * 16384 + len / 2) / len;
      r.nx = x[0] < 0 ? -16'(q) : 16'(q);
      q = (mag[1] * 16384 + len / 2) / len;
      r.ny = x[1] < 0 ? -16'(q) : 16'(q);
      q = (mag[2] * 16384 + len / 2) / len;
      r.nz = x[2] < 0 ? -16'(q) : 16'(q);
      return r;
   endfunction

   // Applies one accepted transaction to the local stores.
   task automatic predict_transaction(kind_type k, int a, int b, int c,
                                      logic signed [15:0] cx, cy, cz);
      normal_result_type r;
      case (k)
         KIND_VERTEX: begin
            vertex_mem[a][0] = cx;
            vertex_mem[a][1] = cy;
            vertex_mem[a][2] = cz;
            vertex_written[a] = 1'b1;
         end
         KIND_CLEAR: begin
            foreach (normal_ok[i]) normal_ok[i] = 1'b0;
         end
         KIND_FACE: begin
            r = face_unit_normal(a, b, c);
            normal_mem[a] = r; normal_ok[a] = 1'b1;
            normal_mem[b] = r; normal_ok[b] = 1'b1;
            normal_mem[c] = r; normal_ok[c] = 1'b1;
            pending_normals = {pending_normals, r};
         end
         default: begin
            r = normal_ok[a] ? normal_mem[a] : '0;
            r.degenerate = 1'b0;
            r.from_read = 1'b1;
            pending_normals = {pending_normals, r};
         end
      endcase
   endtask

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   // Sends one transaction and waits for it to be accepted.
   task automatic send_transaction(kind_type k, int a, int b, int c,
                                   logic signed [15:0] cx, cy, cz, bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_first_index <= 10'(a);
      req_second_index <= 10'(b);
      req_third_index <= 10'(c);
      req_coord_x <= cx;
      req_coord_y <= cy;
      req_coord_z <= cz;
      do @(posedge clock); while (req_stall);
      predict_transaction(k, a, b, c, cx, cy, cz);
   endtask

   task automatic write_vertex(int a, logic signed [15:0] cx, cy, cz, bit gaps);
      send_transaction(KIND_VERTEX, a, 0, 0, cx, cy, cz, gaps);
   endtask

   // Picks a written vertex index.
   function automatic int written_index();
      int i;
      do i = $urandom_range(0, VertexCount - 1); while (!vertex_written[i]);
      return i;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Result checker.
   always @(posedge clock) begin
      normal_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_normals.pop_front();
            if (rsp_normal_x !== want.nx)
               report_mismatch($sformatf("normal_x %0d want %0d", rsp_normal_x, want.nx));
            if (rsp_normal_y !== want.ny)
               report_mismatch($sformatf("normal_y %0d want %0d", rsp_normal_y, want.ny));
            if (rsp_normal_z !== want.nz)
               report_mismatch($sformatf("normal_z %0d want %0d", rsp_normal_z, want.nz));
            if (rsp_degenerate !== want.degenerate)
               report_mismatch("degenerate flag");
            if (rsp_from_read !== want.from_read)
               report_mismatch("from_read flag");
         end
      end
   end

   // Result side stalls.
   always @(posedge clock) begin
      if (!stalls_on) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall) begin
         rsp_stall <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_stall <= ($urandom_range(0, 4) == 0);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (!reset && idle_cycles >= IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Extremes of coordinates, degenerate faces, reads of cleared slots.
   task automatic test_directed();
      write_vertex(0, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      write_vertex(1023, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      write_vertex(1, 16'sh7fff, 16'sh8000, 16'sh0000, 0);
      write_vertex(2, 16'sh8000, 16'sh7fff, 16'sh7fff, 0);
      write_vertex(3, 16'sh0100, 0, 0, 0);
      write_vertex(4, 0, 16'sh0100, 0, 0);
      write_vertex(5, 0, 0, 0, 0);
      send_transaction(KIND_READ, 5, 0, 0, 0, 0, 0, 0);
      send_transaction(KIND_FACE, 5, 3, 4, 0, 0, 0, 0);
      send_transaction(KIND_FACE, 0, 1023, 1, 0, 0, 0, 0);
      send_transaction(KIND_FACE, 0, 1, 2, 0, 0, 0, 0);
      send_transaction(KIND_FACE, 1023, 0, 1023, 0, 0, 0, 0);
      send_transaction(KIND_FACE, 3, 3, 3, 0, 0, 0, 0);
      send_transaction(KIND_FACE, 1, 2, 1, 0, 0, 0, 0);
      send_transaction(KIND_READ, 1023, 0, 0, 0, 0, 0, 0);
      send_transaction(KIND_READ, 3, 0, 0, 0, 0, 0, 0);
      send_transaction(KIND_READ, 5, 0, 0, 0, 0, 0, 0);
      send_transaction(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_transaction(KIND_READ, 1023, 0, 0, 0, 0, 0, 0);
      send_transaction(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
      wait_drained();
   endtask

   // Random traffic: mostly faces over written vertices and reads.
   task automatic test_random(int count);
      int roll, a;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            a = (roll < 3) ? (($urandom_range(0, 1) != 0) ? 1023 : 0)
                           : $urandom_range(0, 63);
            write_vertex(a, 16'($urandom), 16'($urandom),
                         (roll < 10) ? 16'($urandom_range(0, 3)) : 16'($urandom), 1);
         end else if (roll < 33) begin
            send_transaction(KIND_CLEAR, $urandom, $urandom, $urandom, 16'($urandom),
                             16'($urandom), 16'($urandom), 1);
         end else if (roll < 65) begin
            send_transaction(KIND_FACE, written_index(), written_index(), written_index(),
                             16'($urandom), 16'($urandom), 16'($urandom), 1);
         end else begin
            a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 70);
            send_transaction(KIND_READ, a, $urandom, $urandom, 16'($urandom),
                             16'($urandom), 16'($urandom), 1);
         end
         if (n == count / 2) stalls_on = 1'b0;
         if (n == count * 3 / 4) stalls_on = 1'b1;
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1180);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/tfn_pkg.sv
sv/triangle_face_normal_scatter_core.sv
tb/triangle_face_normal_scatter_core_test.sv
